FILE: src/fit_policy_block_allocator_core_defines.svh
// Assertion macros for the allocator core.
// Define NO_ASSERTIONS to drop every check from the build.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FPBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpba check failed");

// next-cycle implication
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpba check failed");

`else

`define FPBA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/fpba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

   // fit policy codes
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // request kinds (req_tuser)
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_FIT_POLICY  = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   localparam int POLICY_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;
   localparam int CHOSEN_WIDTH = 4;

   // control half of the scan token passed cell to cell
   typedef struct packed {
      logic                    valid;
      logic                    found;
      logic [POLICY_WIDTH-1:0] policy;
   } tok_ctrl_type;

endpackage

`default_nettype wire

FILE: src/fpba_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module fpba_cell #(
   parameter int SIZE_WIDTH = 32,
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       active,
   // scan token from the left neighbor
   input  fpba_pkg::tok_ctrl_type    tok_ctrl_i,
   input  wire      [SIZE_WIDTH-1:0] tok_req_i,
   input  wire      [SIZE_WIDTH-1:0] tok_val_i,
   input  wire      [IDX_W-1:0]      tok_idx_i,
   // scan token to the right neighbor
   output fpba_pkg::tok_ctrl_type    tok_ctrl_o,
   output logic     [SIZE_WIDTH-1:0] tok_req_o,
   output logic     [SIZE_WIDTH-1:0] tok_val_o,
   output logic     [IDX_W-1:0]      tok_idx_o,
   // write bus shared by all cells
   input  wire                       upd_en,
   input  wire      [IDX_W-1:0]      upd_idx,
   input  wire      [SIZE_WIDTH-1:0] upd_data
);

   logic [SIZE_WIDTH-1:0]  size_ff;
   fpba_pkg::tok_ctrl_type ctrl_ff, ctrl_in;
   logic [SIZE_WIDTH-1:0]  req_ff, val_ff, val_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   logic fits, better, take;

   always_comb begin
      fits = active && tok_ctrl_i.valid && (size_ff >= tok_req_i);
      unique case (tok_ctrl_i.policy)
         fpba_pkg::FIT_BEST:  better = size_ff < tok_val_i;
         fpba_pkg::FIT_WORST: better = size_ff > tok_val_i;
         default:             better = 1'b0;
      endcase
      take = fits && (!tok_ctrl_i.found || better);

      ctrl_in       = tok_ctrl_i;
      ctrl_in.found = tok_ctrl_i.found || take;
      val_in        = take ? size_ff : tok_val_i;
      idx_in        = take ? IDX_W'(CELL_INDEX) : tok_idx_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      req_ff <= tok_req_i;
      val_ff <= val_in;
      idx_ff <= idx_in;
      if (upd_en && (upd_idx == IDX_W'(CELL_INDEX))) begin
         size_ff <= upd_data;
      end
   end

   assign tok_ctrl_o = ctrl_ff;
   assign tok_req_o  = req_ff;
   assign tok_val_o  = val_ff;
   assign tok_idx_o  = idx_ff;

endmodule

`default_nettype wire

FILE: src/fit_policy_block_allocator_core.sv
// Allocate: the token walks the chain one cell per cycle; its result goes to the output
//   register, or parks in HOLD, and no new item is taken before the core is back in idle.
// Load: no result; loads may follow each other every cycle while the core is idle.
// Reset (synchronous, active high): fit_policy 0, block_count 16, chain and result empty.
//   Block sizes are not cleared; a block must be loaded before it is scanned.
`timescale 1ns / 1ps
`default_nettype none

`include "fit_policy_block_allocator_core_defines.svh"

module fit_policy_block_allocator_core #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // [3:0] block_index, [35:4] size, [39:36] zero
   input  wire         req_tuser,   // [0] req_type
   // response stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] granted, [4:1] chosen_block, [7:5] zero
   // register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW    = fpba_pkg::CHOSEN_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   logic [fpba_pkg::POLICY_WIDTH-1:0] fit_policy_ff;
   logic [fpba_pkg::COUNT_WIDTH-1:0]  block_count_ff;
   logic                              csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff  <= fpba_pkg::FIT_FIRST;
         block_count_ff <= fpba_pkg::COUNT_WIDTH'(16);
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            fpba_pkg::CSR_FIT_POLICY:
               fit_policy_ff <= csr_pwdata[fpba_pkg::POLICY_WIDTH-1:0];
            fpba_pkg::CSR_BLOCK_COUNT:
               block_count_ff <= csr_pwdata[fpba_pkg::COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         fpba_pkg::CSR_FIT_POLICY:  csr_prdata = 32'(fit_policy_ff);
         fpba_pkg::CSR_BLOCK_COUNT: csr_prdata = 32'(block_count_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic                  req_fire, alloc_fire, load_fire;
   logic [3:0]            req_index;
   logic [SIZE_WIDTH-1:0] req_size;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_index  = req_tdata[3:0];
   assign req_size   = SIZE_WIDTH'(req_tdata[35:4]);
   assign alloc_fire = req_fire && (req_tuser == fpba_pkg::REQ_ALLOC);
   // loads past the last block are dropped
   assign load_fire  = req_fire && (req_tuser == fpba_pkg::REQ_LOAD)
                       && (32'(req_index) < 32'(NUM_BLOCKS));

   // ---------------------------------------------------------------------------------
   // Cell chain. Link 0 is the injected token, link j+1 is the output of cell j.
   // ---------------------------------------------------------------------------------
   fpba_pkg::tok_ctrl_type tok_ctrl [NUM_BLOCKS+1];
   logic [SIZE_WIDTH-1:0]  tok_req  [NUM_BLOCKS+1];
   logic [SIZE_WIDTH-1:0]  tok_val  [NUM_BLOCKS+1];
   logic [IDX_W-1:0]       tok_idx  [NUM_BLOCKS+1];
   logic [NUM_BLOCKS-1:0]  cell_active;
   logic [NUM_BLOCKS-1:0]  chain_busy;

   logic                  upd_en;
   logic [IDX_W-1:0]      upd_idx;
   logic [SIZE_WIDTH-1:0] upd_data;

   assign tok_ctrl[0] = '{valid: alloc_fire, found: 1'b0, policy: fit_policy_ff};
   assign tok_req[0]  = req_size;
   assign tok_val[0]  = '0;
   assign tok_idx[0]  = '0;

   for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
      // block_count never exceeds 31, so cells from 32 up never take part
      if (j < 32) begin : g_act
         assign cell_active[j] = (fpba_pkg::COUNT_WIDTH'(j) < block_count_ff);
      end else begin : g_off
         assign cell_active[j] = 1'b0;
      end

      assign chain_busy[j] = tok_ctrl[j+1].valid;

      fpba_cell #(
         .SIZE_WIDTH (SIZE_WIDTH),
         .IDX_W      (IDX_W),
         .CELL_INDEX (j)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .active     (cell_active[j]),
         .tok_ctrl_i (tok_ctrl[j]),
         .tok_req_i  (tok_req[j]),
         .tok_val_i  (tok_val[j]),
         .tok_idx_i  (tok_idx[j]),
         .tok_ctrl_o (tok_ctrl[j+1]),
         .tok_req_o  (tok_req[j+1]),
         .tok_val_o  (tok_val[j+1]),
         .tok_idx_o  (tok_idx[j+1]),
         .upd_en     (upd_en),
         .upd_idx    (upd_idx),
         .upd_data   (upd_data)
      );
   end

   // ---------------------------------------------------------------------------------
   // Write-back: the chosen block drops by the request when the token leaves the
   // chain. Loads only happen in idle, so the two never meet on the bus.
   // ---------------------------------------------------------------------------------
   fpba_pkg::tok_ctrl_type exit_ctrl;
   logic                   exit_done, commit;

   assign exit_ctrl = tok_ctrl[NUM_BLOCKS];
   assign exit_done = (state_ff == ST_SCAN) && exit_ctrl.valid;
   assign commit    = exit_done && exit_ctrl.found;

   always_comb begin
      upd_en   = load_fire || commit;
      upd_idx  = commit ? tok_idx[NUM_BLOCKS] : IDX_W'(req_index);
      upd_data = commit ? (tok_val[NUM_BLOCKS] - tok_req[NUM_BLOCKS]) : req_size;
   end

   // ---------------------------------------------------------------------------------
   // Sequencer and result register. A result that cannot go out yet parks in the
   // pending register (HOLD); the output register lets a new item in while the
   // last result waits.
   // ---------------------------------------------------------------------------------
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_granted_ff, rsp_granted_in;
   logic [CW-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic          pend_granted_ff, pend_granted_in;
   logic [CW-1:0] pend_chosen_ff, pend_chosen_in;
   logic          out_free;
   logic [CW-1:0] exit_chosen;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign exit_chosen = exit_ctrl.found ? CW'(tok_idx[NUM_BLOCKS]) : '0;

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_granted_in  = rsp_granted_ff;
      rsp_chosen_in   = rsp_chosen_ff;
      pend_granted_in = pend_granted_ff;
      pend_chosen_in  = pend_chosen_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (alloc_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (exit_ctrl.valid) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = exit_ctrl.found;
                  rsp_chosen_in  = exit_chosen;
                  state_in       = ST_IDLE;
               end else begin
                  pend_granted_in = exit_ctrl.found;
                  pend_chosen_in  = exit_chosen;
                  state_in        = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = pend_granted_ff;
               rsp_chosen_in  = pend_chosen_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_granted_ff  <= rsp_granted_in;
      rsp_chosen_ff   <= rsp_chosen_in;
      pend_granted_ff <= pend_granted_in;
      pend_chosen_ff  <= pend_chosen_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_chosen_ff, rsp_granted_ff};

   // ---------------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------------
   // no scan token may be in flight while new items are taken
   `FPBA_ASSERT_IMPL(a_idle_chain_empty, clock, reset, req_tready, chain_busy == '0)
   // the token leaving the chain always ends the scan
   `FPBA_ASSERT_NEXT(a_scan_ends, clock, reset, exit_done, state_ff != ST_SCAN)
   // a granted block lies inside the scanned range
   `FPBA_ASSERT_IMPL(a_pick_in_range, clock, reset, commit,
                     32'(tok_idx[NUM_BLOCKS]) < 32'(block_count_ff))

endmodule

`default_nettype wire
